/* hw/rtl/pollard_rho_factor_attempt_defines.svh */
// Assertion macros for the rho factor attempt block.
`ifndef POLLARD_RHO_FACTOR_ATTEMPT_DEFINES_SVH
`define POLLARD_RHO_FACTOR_ATTEMPT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PRFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prfa check failed");

// antecedent implies consequent in the next cycle
`define PRFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prfa check failed");

`endif

/* hw/rtl/prfa_pkg.sv */
// ----------------------------------------------------------------------------
// prfa_pkg
// Shared constants and types of the rho factor attempt block.
// ----------------------------------------------------------------------------
package prfa_pkg;

  localparam int VB     = 63;
  localparam int LGW    = 5;
  localparam int RW     = 31;
  localparam int CW     = $clog2(VB + 1);
  localparam logic [LGW-1:0] LG_MAX = LGW'(30);

  typedef struct packed {
    logic          start;
    logic [VB-1:0] dividend;
    logic [VB-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [VB-1:0] quotient;
    logic [VB-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/pollard_rho_factor_attempt.sv */
// Setup reduces the increment and start value modulo the composite with two
// divides; each round runs a shift-add square and a binary gcd; a found factor
// adds a divide. Throughput: one word at a time; the next word is taken after
// the result leaves. The square and gcd loops share the sequencer below.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// pollard_rho_factor_attempt
// One Brent-style rho attempt per input word, shift-add modular square,
// binary gcd and restoring divide.
// ----------------------------------------------------------------------------
`include "pollard_rho_factor_attempt_defines.svh"

module pollard_rho_factor_attempt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [prfa_pkg::VB-1:0]      in_composite,
  input  logic [prfa_pkg::VB-1:0]      in_increment,
  input  logic [prfa_pkg::VB-1:0]      in_start_value,
  input  logic [prfa_pkg::LGW-1:0]     in_round_log2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [prfa_pkg::VB-1:0]      out_smaller_factor,
  output logic [prfa_pkg::VB-1:0]      out_larger_factor
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MODC = 4'd1;
  localparam logic [3:0] S_MODX = 4'd2;
  localparam logic [3:0] S_SQR  = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DIVQ = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam int VB = prfa_pkg::VB;

  logic [3:0]                 state_r, state_nxt;
  logic [VB-1:0]              n_r, n_nxt, c_r, c_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [prfa_pkg::LGW-1:0]   lg_r, lg_nxt;
  logic [prfa_pkg::RW-1:0]    r_r, r_nxt, lim;
  logic [VB-1:0]              acc_r, acc_nxt, add_r, add_nxt, bits_r, bits_nxt;
  logic [VB-1:0]              ga_r, ga_nxt, gb_r, gb_nxt, g_r, g_nxt;
  logic [prfa_pkg::CW-1:0]    gk_r, gk_nxt;
  logic                       found_r, found_nxt;
  logic [VB-1:0]              small_r, small_nxt, large_r, large_nxt;
  logic [VB:0]                s_sum, a_sum;
  logic [VB-1:0]              acc_step, add_step, z, gdiff_ab, gdiff_ba;
  prfa_pkg::div_req_t         dreq;
  prfa_pkg::div_rsp_t         drsp;

  prfa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign lim = prfa_pkg::RW'(1) << lg_r;

  always_comb begin
    s_sum    = {1'b0, acc_r} + {1'b0, add_r};
    acc_step = (s_sum >= {1'b0, n_r}) ? VB'(s_sum - {1'b0, n_r}) : VB'(s_sum);
    a_sum    = {1'b0, add_r} + {1'b0, add_r};
    add_step = (a_sum >= {1'b0, n_r}) ? VB'(a_sum - {1'b0, n_r}) : VB'(a_sum);
    z        = (x_r < y_r) ? (n_r - y_r + x_r) : (x_r - y_r);
    gdiff_ab = ga_r - gb_r;
    gdiff_ba = gb_r - ga_r;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;  c_nxt = c_r;  x_nxt = x_r;  y_nxt = y_r;
    lg_nxt = lg_r;  r_nxt = r_r;
    acc_nxt = acc_r;  add_nxt = add_r;  bits_nxt = bits_r;
    ga_nxt = ga_r;  gb_nxt = gb_r;  gk_nxt = gk_r;  g_nxt = g_r;
    found_nxt = found_r;  small_nxt = small_r;  large_nxt = large_r;
    dreq.start    = 1'b0;
    dreq.dividend = c_r;
    dreq.divisor  = n_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_composite;
          c_nxt     = in_increment;
          x_nxt     = in_start_value;
          lg_nxt    = (in_round_log2 > prfa_pkg::LG_MAX) ? prfa_pkg::LG_MAX : in_round_log2;
          found_nxt = 1'b0;
          small_nxt = '0;
          large_nxt = '0;
          if (in_composite < VB'(2)) begin
            state_nxt = S_OUT;
          end else begin
            dreq.start    = 1'b1;
            dreq.dividend = in_increment;
            dreq.divisor  = in_composite;
            state_nxt     = S_MODC;
          end
        end
      end
      S_MODC: begin
        if (drsp.done) begin
          c_nxt         = drsp.remainder;
          dreq.start    = 1'b1;
          dreq.dividend = x_r;
          state_nxt     = S_MODX;
        end
      end
      S_MODX: begin
        if (drsp.done) begin
          x_nxt    = drsp.remainder;
          y_nxt    = drsp.remainder;
          r_nxt    = prfa_pkg::RW'(1);
          g_nxt    = '0;
          acc_nxt  = c_r;
          add_nxt  = drsp.remainder;
          bits_nxt = drsp.remainder;
          state_nxt = (lg_r == '0) ? S_FIN : S_SQR;
        end
      end
      S_SQR: begin
        if (bits_r == '0) begin
          x_nxt     = acc_r;
          state_nxt = S_DIFF;
        end else begin
          if (bits_r[0]) acc_nxt = acc_step;
          add_nxt  = add_step;
          bits_nxt = bits_r >> 1;
        end
      end
      S_DIFF: begin
        ga_nxt    = z;
        gb_nxt    = n_r;
        gk_nxt    = '0;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        priority if (ga_r == '0) begin
          g_nxt     = VB'(gb_r << gk_r);
          state_nxt = S_CHK;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          gk_nxt = gk_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          ga_nxt = gdiff_ab >> 1;
        end else begin
          gb_nxt = gdiff_ba >> 1;
        end
      end
      S_CHK: begin
        if (g_r != VB'(1)) begin
          state_nxt = S_FIN;
        end else begin
          if ((r_r & (r_r - 1'b1)) == '0) y_nxt = x_r;
          if ((r_r + 1'b1) == lim) begin
            state_nxt = S_FIN;
          end else begin
            r_nxt     = r_r + 1'b1;
            acc_nxt   = c_r;
            add_nxt   = x_r;
            bits_nxt  = x_r;
            state_nxt = S_SQR;
          end
        end
      end
      S_FIN: begin
        if (g_r > VB'(1) && g_r < n_r) begin
          dreq.start    = 1'b1;
          dreq.dividend = n_r;
          dreq.divisor  = g_r;
          state_nxt     = S_DIVQ;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVQ: begin
        if (drsp.done) begin
          found_nxt = 1'b1;
          small_nxt = (g_r > drsp.quotient) ? drsp.quotient : g_r;
          large_nxt = (g_r > drsp.quotient) ? g_r : drsp.quotient;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt;  c_r <= c_nxt;  x_r <= x_nxt;  y_r <= y_nxt;
    lg_r <= lg_nxt;  r_r <= r_nxt;
    acc_r <= acc_nxt;  add_r <= add_nxt;  bits_r <= bits_nxt;
    ga_r <= ga_nxt;  gb_r <= gb_nxt;  gk_r <= gk_nxt;  g_r <= g_nxt;
    found_r <= found_nxt;  small_r <= small_nxt;  large_r <= large_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_found          = found_r;
  assign out_smaller_factor = small_r;
  assign out_larger_factor  = large_r;

  `PRFA_ASSERT_IMPL(a_order, out_valid && out_found, out_smaller_factor <= out_larger_factor)
  `PRFA_ASSERT_IMPL(a_zero, out_valid && !out_found,
                    out_smaller_factor == '0 && out_larger_factor == '0)
  `PRFA_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)

endmodule

/* hw/rtl/prfa_div.sv */
// ----------------------------------------------------------------------------
// prfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prfa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  prfa_pkg::div_req_t req,
  output prfa_pkg::div_rsp_t rsp
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [prfa_pkg::CW-1:0]   cnt_r, cnt_nxt;
  logic [prfa_pkg::VB:0]     rem_r, rem_nxt;
  logic [prfa_pkg::VB-1:0]   quo_r, quo_nxt;
  logic [prfa_pkg::VB-1:0]   d_r, d_nxt;
  logic [prfa_pkg::VB:0]     t;
  logic                      ge;

  always_comb begin
    t        = {rem_r[prfa_pkg::VB-1:0], quo_r[prfa_pkg::VB-1]};
    ge       = (t >= {1'b0, d_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (t - {1'b0, d_r}) : t;
      quo_nxt = {quo_r[prfa_pkg::VB-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == prfa_pkg::CW'(prfa_pkg::VB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[prfa_pkg::VB-1:0];

endmodule

/* dv/pollard_rho_factor_attempt_checker.sv */
// ----------------------------------------------------------------------------
// pollard_rho_factor_attempt_checker
// Watches both channels, computes the expected factor result of every
// accepted word and compares it with what comes out, oldest first.
// ----------------------------------------------------------------------------
module pollard_rho_factor_attempt_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [prfa_pkg::VB-1:0]  in_composite,
  input  logic [prfa_pkg::VB-1:0]  in_increment,
  input  logic [prfa_pkg::VB-1:0]  in_start_value,
  input  logic [prfa_pkg::LGW-1:0] in_round_log2,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_found,
  input  logic [prfa_pkg::VB-1:0]  out_smaller_factor,
  input  logic [prfa_pkg::VB-1:0]  out_larger_factor,
  output int                       errors,
  output int                       pending,
  output int                       found_seen
);

  typedef struct packed {
    logic                    found;
    logic [prfa_pkg::VB-1:0] lo;
    logic [prfa_pkg::VB-1:0] hi;
  } split_t;

  split_t split_q[$];

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] square_step(logic [63:0] x, logic [63:0] c,
                                              logic [63:0] n);
    logic [63:0] acc, add, bits;
    acc = c;
    add = x;
    bits = x;
    while (bits != 0) begin
      if (bits[0]) begin
        acc += add;
        if (acc >= n) acc -= n;
      end
      add += add;
      if (add >= n) add -= n;
      bits >>= 1;
    end
    return acc;
  endfunction

  function automatic split_t rho_split(logic [prfa_pkg::VB-1:0] comp,
                                       logic [prfa_pkg::VB-1:0] inc,
                                       logic [prfa_pkg::VB-1:0] sv,
                                       logic [prfa_pkg::LGW-1:0] lgi);
    split_t res;
    logic [63:0] n, c, x, y, z, g, p1, p2;
    int unsigned lg, lim, r;
    res = '0;
    n = {1'b0, comp};
    if (n < 2) return res;
    lg = (lgi > prfa_pkg::LG_MAX) ? prfa_pkg::LG_MAX : lgi;
    c = {1'b0, inc} % n;
    x = {1'b0, sv} % n;
    y = x;
    g = 0;
    lim = 32'd1 << lg;
    for (r = 1; r < lim; r++) begin
      x = square_step(x, c, n);
      z = (x < y) ? (n - y) + x : x - y;
      g = gcd64(z, n);
      if (g != 1) break;
      if ((r & (r - 1)) == 0) y = x;
    end
    if (g > 1 && g < n) begin
      p1 = g;
      p2 = n / g;
      res.found = 1'b1;
      res.lo = (p1 < p2) ? p1[prfa_pkg::VB-1:0] : p2[prfa_pkg::VB-1:0];
      res.hi = (p1 < p2) ? p2[prfa_pkg::VB-1:0] : p1[prfa_pkg::VB-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    split_t exp_s;
    if (!rst_n) begin
      errors = 0;
      found_seen = 0;
      split_q.delete();
    end else begin
      if (in_valid && !in_stall)
        split_q.push_back(rho_split(in_composite, in_increment, in_start_value,
                                    in_round_log2));
      if (out_valid && !out_stall) begin
        if (split_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_s = split_q.pop_front();
          if (out_found) found_seen++;
          if (out_found !== exp_s.found) begin
            $error("found: expected %0d, got %0d", exp_s.found, out_found);
            errors++;
          end
          if (out_smaller_factor !== exp_s.lo) begin
            $error("smaller_factor: expected %0d, got %0d", exp_s.lo,
                   out_smaller_factor);
            errors++;
          end
          if (out_larger_factor !== exp_s.hi) begin
            $error("larger_factor: expected %0d, got %0d", exp_s.hi,
                   out_larger_factor);
            errors++;
          end
        end
      end
    end
    pending = split_q.size();
  end

endmodule

/* dv/pollard_rho_factor_attempt_test.sv */
// ----------------------------------------------------------------------------
// pollard_rho_factor_attempt_test
// Drives directed and random factoring words with random gaps and output
// stalls; the checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module pollard_rho_factor_attempt_test;

  localparam int WATCHDOG = 2000000;
  localparam int N_RAND   = 100;
  localparam int CALM     = 20;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_found;
  logic [prfa_pkg::VB-1:0] in_composite, in_increment, in_start_value;
  logic [prfa_pkg::LGW-1:0] in_round_log2;
  logic [prfa_pkg::VB-1:0] out_smaller_factor, out_larger_factor;
  int errors, pending, found_seen;
  int idle_cnt, sent;
  bit calm, timed_out;

  pollard_rho_factor_attempt u_top (.*);

  pollard_rho_factor_attempt_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // output stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic send_word(logic [prfa_pkg::VB-1:0] n, logic [prfa_pkg::VB-1:0] c,
                           logic [prfa_pkg::VB-1:0] x, logic [prfa_pkg::LGW-1:0] lg);
    @(negedge clk);
    if (!calm && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 14)) @(negedge clk);
    in_valid <= 1'b1;
    in_composite <= n;
    in_increment <= c;
    in_start_value <= x;
    in_round_log2 <= lg;
    #1;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [prfa_pkg::VB-1:0] rnd_val();
    return prfa_pkg::VB'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [prfa_pkg::VB-1:0] p, q;
    sent = 0;
    calm = 1'b0;
    timed_out = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_composite = '0;
    in_increment = '0;
    in_start_value = '0;
    in_round_log2 = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    fork
      begin
        wait (idle_cnt >= WATCHDOG);
        timed_out = 1'b1;
      end
      begin
        // composite zero and one
        send_word('0, 63'd5, 63'd7, 5'd4);
        send_word(63'd1, '1, '1, 5'd4);
        // round exponent zero
        send_word(63'd15, 63'd1, 63'd2, 5'd0);
        // tiny composites with saturated and top exponents
        send_word(63'd4, 63'd1, 63'd1, 5'd30);
        send_word(63'd6, 63'd3, 63'd5, 5'd31);
        send_word(63'd9, 63'd0, 63'd3, 5'd16);
        // walk collision
        send_word(63'd6, 63'd0, 63'd1, 5'd3);
        // increment and start not below composite
        send_word(63'd15, 63'd20, 63'd100, 5'd5);
        // all-ones composite, with all-ones and with small fields
        send_word('1, '1, '1, 5'd4);
        send_word('1, '0, 63'd1, 5'd1);
        // primes
        send_word(63'd1000003, 63'd1, 63'd2, 5'd4);
        send_word(63'd2, 63'd1, 63'd1, 5'd3);
        // large prime cofactor, then two mid-sized primes
        send_word(63'd3 * ((63'd1 << 61) - 1), 63'd1, 63'd2, 5'd5);
        send_word(63'd1009 * 63'd1013, 63'd1, 63'd2, 5'd6);

        for (int i = 0; i < N_RAND; i++) begin
          if (i == N_RAND - CALM) calm = 1'b1;
          if (i == N_RAND / 2) wait (pending == 0);
          case ($urandom_range(0, 9))
            0: send_word(63'($urandom_range(0, 1)), rnd_val(), rnd_val(),
                         5'($urandom_range(0, 31)));
            1, 2: send_word(rnd_val(), rnd_val(), rnd_val(),
                            5'($urandom_range(1, 4)));
            default: begin
              p = prfa_pkg::VB'($urandom_range(2, 2000));
              q = rnd_val() / p;
              if (q < 2) q = 2;
              send_word(p * q, rnd_val(), rnd_val(), 5'($urandom_range(1, 6)));
            end
          endcase
        end
        wait (pending == 0);
        repeat (50) @(negedge clk);
      end
    join_any

    if (timed_out) begin
      $display("FAIL pollard_rho_factor_attempt");
    end else begin
      $display("Sent %0d words, %0d results reported a split factor.", sent,
               found_seen);
      if (errors == 0)
        $display("PASS pollard_rho_factor_attempt");
      else
        $display("FAIL pollard_rho_factor_attempt");
    end
    $finish;
  end

endmodule
